### rtl/egs_pkg.sv
// Package for the eight-step gate sequencer.
// Holds request/response/config types, field widths, reset values and register indexes.
// No dependencies.
package egs_pkg;

   localparam int NUM_STEPS_DEF  = 8;
   localparam int PHASE_BITS_DEF = 32;

   localparam int TEMPO_W    = 9;
   localparam int DELTA_W    = 4;
   localparam int INC_W      = 16;
   localparam int DUTY_W     = 32;
   localparam int OUT_STEP_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [INC_W-1:0]  INC_RESET  = INC_W'(746);
   localparam logic [DUTY_W-1:0] DUTY_RESET = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_INC = 2'd0,
      CSR_DUTY      = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic [TEMPO_W-1:0]        tempo_bpm;
      logic                      mode_press;
      logic signed [DELTA_W-1:0] encoder_delta;
      logic                      toggle_press;
   } req_type;

   typedef struct packed {
      logic                  gate_out;
      logic [OUT_STEP_W-1:0] play_step;
      logic [OUT_STEP_W-1:0] edit_step;
      logic                  view_mode;
      logic [OUT_STEP_W-1:0] led_step;
      logic                  led_on;
   } rsp_type;

   typedef struct packed {
      logic [INC_W-1:0]  phase_inc_per_bpm;
      logic [DUTY_W-1:0] duty_threshold;
   } cfg_type;

endpackage

### rtl/eight_step_gate_sequencer_top.sv
// Top level of the eight-step gate sequencer: request register, result register, handshakes.
// Depends on egs_pkg, egs_csr and egs_core.
//
// One request per clock cycle, sustained while no response is held under rsp_stall. A request
// enters an input register, is processed from there against the sequencer state (control events, then
// the phase add with a 9x16 multiply, wrap check and duty compare) and its response is loaded into
// the result register, which raises rsp_valid; a response held under rsp_stall keeps it waiting.
// The response register lets the next request enter while a finished response waits under
// rsp_stall. Configuration writes are always ready and take effect once registered in egs_csr;
// write them only while idle.
module eight_step_gate_sequencer_top #(
   parameter int NUM_STEPS  = egs_pkg::NUM_STEPS_DEF,
   parameter int PHASE_BITS = egs_pkg::PHASE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  egs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output egs_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [egs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [egs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import egs_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   cfg_type cfg;
   logic    advance;
   logic    accept;

   assign csr_ready = 1'b1;

   assign advance     = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   egs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   egs_core #(
      .NUM_STEPS  (NUM_STEPS),
      .PHASE_BITS (PHASE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/egs_csr.sv
// Configuration registers of the gate sequencer: phase increment and duty threshold.
// Depends on egs_pkg.
module egs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [egs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [egs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output egs_pkg::cfg_type                 cfg
);
   import egs_pkg::*;

   logic [INC_W-1:0]  inc_ff;
   logic [INC_W-1:0]  inc_in;
   logic [DUTY_W-1:0] duty_ff;
   logic [DUTY_W-1:0] duty_in;

   always_comb begin
      inc_in  = inc_ff;
      duty_in = duty_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PHASE_INC: inc_in  = csr_wdata[INC_W-1:0];
            CSR_DUTY:      duty_in = csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff  <= INC_RESET;
         duty_ff <= DUTY_RESET;
      end else begin
         inc_ff  <= inc_in;
         duty_ff <= duty_in;
      end
   end

   assign cfg.phase_inc_per_bpm = inc_ff;
   assign cfg.duty_threshold    = duty_ff;

endmodule

### rtl/egs_core.sv
// Sequencer state and per-request update: mode, cursor, pattern, phase accumulator, play step.
// Depends on egs_pkg.
module egs_core #(
   parameter int NUM_STEPS  = egs_pkg::NUM_STEPS_DEF,
   parameter int PHASE_BITS = egs_pkg::PHASE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  egs_pkg::req_type item,
   input  egs_pkg::cfg_type cfg,
   output egs_pkg::rsp_type result
);
   import egs_pkg::*;

   localparam int STEP_W = $clog2(NUM_STEPS);
   localparam int POS_W  = STEP_W + 5;
   localparam int PROD_W = TEMPO_W + INC_W;
   localparam int SUM_W  = ((PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W) + 1;
   localparam int CMP_W  = (PHASE_BITS > DUTY_W) ? PHASE_BITS : DUTY_W;
   localparam logic signed [POS_W-1:0] STEPS_S = POS_W'(NUM_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   logic [NUM_STEPS-1:0]  pattern_ff;
   logic [NUM_STEPS-1:0]  pattern_in;
   logic [STEP_W-1:0]     cursor_ff;
   logic [STEP_W-1:0]     cursor_in;
   logic [STEP_W-1:0]     play_ff;
   logic [STEP_W-1:0]     play_in;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic                  latched_ff;
   logic                  latched_in;
   logic                  mode_ff;
   logic                  mode_in;

   logic [PROD_W-1:0]       prod;
   logic [SUM_W-1:0]        sum;
   logic                    wrap;
   logic signed [POS_W-1:0] cursor_sum;

   function automatic logic [STEP_W-1:0] wrap_pos(input logic signed [POS_W-1:0] v);
      logic signed [POS_W-1:0] r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (r < 0) begin
            r = r + STEPS_S;
         end else if (r >= STEPS_S) begin
            r = r - STEPS_S;
         end
      end
      return r[STEP_W-1:0];
   endfunction

   function automatic logic [OUT_STEP_W-1:0] to_out(input logic [STEP_W-1:0] s);
      logic [STEP_W+OUT_STEP_W-1:0] w;
      w = (STEP_W + OUT_STEP_W)'(s);
      return w[OUT_STEP_W-1:0];
   endfunction

   assign cursor_sum = signed'(POS_W'(cursor_ff)) + POS_W'(item.encoder_delta);
   assign prod = PROD_W'(item.tempo_bpm) * PROD_W'(cfg.phase_inc_per_bpm);
   assign sum  = SUM_W'(phase_ff) + SUM_W'(prod);
   assign wrap = |sum[SUM_W-1:PHASE_BITS];

   always_comb begin
      mode_in    = mode_ff ^ item.mode_press;
      cursor_in  = cursor_ff;
      pattern_in = pattern_ff;
      if (!mode_in) begin
         cursor_in = wrap_pos(cursor_sum);
         if (item.toggle_press) begin
            pattern_in[cursor_in] = ~pattern_ff[cursor_in];
         end
      end
      play_in    = play_ff;
      latched_in = latched_ff;
      if (wrap) begin
         play_in    = (play_ff == LAST_STEP) ? '0 : play_ff + 1'b1;
         latched_in = pattern_in[play_in];
      end
      phase_in = sum[PHASE_BITS-1:0];
   end

   always_comb begin
      result.gate_out  = (CMP_W'(phase_in) < CMP_W'(cfg.duty_threshold)) && latched_in;
      result.play_step = to_out(play_in);
      result.edit_step = to_out(cursor_in);
      result.view_mode = mode_in;
      result.led_step  = mode_in ? to_out(play_in) : to_out(cursor_in);
      result.led_on    = mode_in ? latched_in : pattern_in[cursor_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         cursor_ff  <= '0;
         play_ff    <= '0;
         phase_ff   <= '0;
         latched_ff <= 1'b0;
         mode_ff    <= 1'b0;
      end else if (advance) begin
         pattern_ff <= pattern_in;
         cursor_ff  <= cursor_in;
         play_ff    <= play_in;
         phase_ff   <= phase_in;
         latched_ff <= latched_in;
         mode_ff    <= mode_in;
      end
   end

`ifndef SYNTH
   a_play_range: assert property (@(posedge clock) disable iff (reset)
      int'(play_ff) < NUM_STEPS)
      else $error("play step out of range");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      int'(cursor_ff) < NUM_STEPS)
      else $error("edit cursor out of range");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(pattern_ff) && $stable(play_ff))
      else $error("state moved without a request");

   a_view_freezes_edit: assert property (@(posedge clock) disable iff (reset)
      advance && mode_ff && !item.mode_press |=> $stable(cursor_ff) && $stable(pattern_ff))
      else $error("cursor or pattern changed in view mode");
`endif

endmodule
